### rtl/vlqenc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlqenc_pkg
// Types, constants and the base64 character map shared by the VLQ encoder.
// ----------------------------------------------------------------------------
package vlqenc_pkg;

  localparam int FIELD_W        = 31;   // width of one segment field
  localparam int VALUE_BITS_DEF = 31;   // default count of encoded value bits
  localparam int GROUP_W        = 5;    // payload bits per character
  localparam int NUM_FIELDS     = 5;
  localparam int FIELD_IDX_W    = 3;
  localparam int CHAR_W         = 7;

  localparam logic [FIELD_IDX_W-1:0] LAST_FIELD = FIELD_IDX_W'(NUM_FIELDS - 1);

  typedef struct packed {
    logic [FIELD_W-1:0] out_column;
    logic [FIELD_W-1:0] source_index;
    logic [FIELD_W-1:0] source_line;
    logic [FIELD_W-1:0] source_column;
    logic [FIELD_W-1:0] name_index;
  } seg_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code_char;
    logic              field_done;
    logic              segment_done;
  } seg_out_t;

  // 6-bit digit to ASCII: A-Z a-z 0-9 + /
  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < 6'd26)       b64_char = 7'd65 + dx;
    else if (d < 6'd52)  b64_char = 7'd71 + dx;   // 'a' - 26
    else if (d < 6'd62)  b64_char = dx - 7'd4;    // '0' - 52
    else if (d == 6'd62) b64_char = 7'd43;        // '+'
    else                 b64_char = 7'd47;        // '/'
  endfunction

endpackage

### rtl/vlq_base64_segment_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlq_base64_segment_encoder
// Base64 VLQ source-map segment encoder, one character per unstalled cycle.
// ----------------------------------------------------------------------------
// A segment transfer on in_ carries five unsigned fields, encoded in order:
// out_column, source_index, source_line, source_column, name_index. Each
// field is taken to its low VALUE_BITS bits, shifted left once (sign bit 0)
// and sent as 5-bit groups, least significant first, one base64 character per
// out_ transfer; all but the last group of a field carry the 0x20
// continuation bit. field_done marks the last character of each field and
// segment_done the last character of the segment. A segment is loaded whole,
// then sent one character at a time by the single 5-bit digit shifter, which
// works through one field at a time. in_ready is high whenever no segment is
// being encoded, so a new segment may be taken while the final character
// still waits in the output register.
module vlq_base64_segment_encoder #(
  parameter int VALUE_BITS = vlqenc_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vlqenc_pkg::seg_in_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vlqenc_pkg::seg_out_t out_data
);
  import vlqenc_pkg::*;

  localparam int CUR_W  = VALUE_BITS + 1;               // value plus sign bit
  localparam int REST_W = VALUE_BITS * (NUM_FIELDS - 1);

  // Low VALUE_BITS of a field, zero-extended when VALUE_BITS > FIELD_W.
  function automatic logic [VALUE_BITS-1:0] trim(input logic [FIELD_W-1:0] x);
    logic [VALUE_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (i < FIELD_W) r[i] = x[i];
    end
    return r;
  endfunction

  // Engine state: value being shifted out, fields still to come, field index.
  logic                   busy_r, busy_nxt;
  logic [CUR_W-1:0]       cur_r, cur_nxt;
  logic [REST_W-1:0]      rest_r, rest_nxt;
  logic [FIELD_IDX_W-1:0] fld_r, fld_nxt;

  // Output register
  logic     out_valid_r, out_valid_nxt;
  seg_out_t out_r, out_nxt;

  logic             in_xfer, step;
  logic [CUR_W-1:0] shifted;
  logic             more;
  logic [5:0]       digit;

  assign in_ready  = !busy_r;
  assign in_xfer   = in_valid && in_ready;
  // Emit a character when the output slot is free or being drained.
  assign step      = busy_r && (!out_valid_r || out_ready);

  assign shifted   = cur_r >> GROUP_W;
  assign more      = (shifted != '0);
  assign digit     = {more, cur_r[GROUP_W-1:0]};

  always_comb begin
    busy_nxt      = busy_r;
    cur_nxt       = cur_r;
    rest_nxt      = rest_r;
    fld_nxt       = fld_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (in_xfer) begin
      busy_nxt = 1'b1;
      fld_nxt  = '0;
      cur_nxt  = {trim(in_data.out_column), 1'b0};
      rest_nxt = {trim(in_data.name_index), trim(in_data.source_column),
                  trim(in_data.source_line), trim(in_data.source_index)};
    end else if (step) begin
      out_valid_nxt        = 1'b1;
      out_nxt.code_char    = b64_char(digit);
      out_nxt.field_done   = !more;
      out_nxt.segment_done = !more && (fld_r == LAST_FIELD);
      if (more) begin
        cur_nxt = shifted;
      end else if (fld_r == LAST_FIELD) begin
        busy_nxt = 1'b0;
      end else begin
        // next field comes from the bottom of the queue
        cur_nxt  = {rest_r[VALUE_BITS-1:0], 1'b0};
        rest_nxt = rest_r >> VALUE_BITS;
        fld_nxt  = fld_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      fld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      fld_r       <= fld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    rest_r <= rest_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_load_starts_first_field: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> busy_r && (fld_r == '0))
    else $error("segment load did not start at the first field");

  a_seg_ends_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.segment_done |-> out_r.field_done)
    else $error("segment_done without field_done");

  a_field_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    fld_r <= LAST_FIELD)
    else $error("field index out of range");

  a_last_char_idles: assert property (@(posedge clk) disable iff (!rst_n)
    step && !more && (fld_r == LAST_FIELD) |=> !busy_r)
    else $error("engine still busy after last character");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the base64 VLQ segment encoder. Segments are sent
// over the in_ channel and the expected base64 characters are built by a
// local VLQ predictor (or typed in for the obvious rows). Each character
// transfer on out_ is checked against the oldest pending character.
// ----------------------------------------------------------------------------
module tb;
  import vlqenc_pkg::*;

  localparam int VALUE_BITS   = VALUE_BITS_DEF;
  localparam int DRAIN_CYCLES = 60;    // longer than one whole segment
  localparam int ITEMS_PER_PH = 85;    // random segments per idle phase
  localparam logic [FIELD_W-1:0] FMAX = '1;

  // base64 digit map, first character in the top byte
  localparam logic [8*64-1:0] B64_DIGITS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  seg_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  seg_out_t out_data;

  // pending characters, oldest first
  seg_out_t expected_chars[$];
  seg_out_t next_char;
  int       mismatch_count;
  int       char_count;

  // idle odds in percent, changed per phase
  int send_idle_pct;
  int recv_idle_pct;

  // directed rows: segment plus an optional typed-in character string
  seg_in_t stim_segs[$];
  string   stim_text[$];

  vlq_base64_segment_encoder #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // One line per mismatch, run keeps going.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns, char %0d: %s", $realtime, char_count, msg);
    mismatch_count++;
  endtask

  // VLQ text for one segment: fields separated by ',' so the field ends can
  // be recovered when the characters are queued.
  function automatic string vlq_segment_text(input seg_in_t seg);
    logic [FIELD_W-1:0] vals [NUM_FIELDS];
    logic [63:0]        v;
    logic [5:0]         digit;
    logic               more;
    string              txt;
    txt = "";
    vals[0] = seg.out_column;
    vals[1] = seg.source_index;
    vals[2] = seg.source_line;
    vals[3] = seg.source_column;
    vals[4] = seg.name_index;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      // keep the low VALUE_BITS, then make room for the (always zero) sign bit
      v = 64'(vals[f]) & ((64'd1 << VALUE_BITS) - 64'd1);
      v = v << 1;
      do begin
        digit[4:0] = v[4:0];
        v          = v >> GROUP_W;
        more       = (v != 64'd0);
        digit[5]   = more;       // continuation bit
        txt = $sformatf("%s%c", txt, B64_DIGITS[8*(63 - int'(digit)) +: 8]);
      end while (more);
      if (f != NUM_FIELDS - 1) txt = {txt, ","};
    end
    return txt;
  endfunction

  // Turn a comma-separated character string into pending characters.
  function automatic void queue_segment_chars(input string txt);
    seg_out_t c;
    byte      ch;
    bool_last: for (int i = 0; i < txt.len(); i++) begin
      if (txt[i] != ",") begin
        ch             = txt[i];
        c.code_char    = ch[CHAR_W-1:0];
        c.segment_done = (i + 1 == txt.len());
        c.field_done   = c.segment_done;
        if (!c.segment_done) begin
          if (txt[i+1] == ",") c.field_done = 1'b1;
        end
        expected_chars = {expected_chars, c};
      end
    end
  endfunction

  function automatic void add_row(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                                  input logic [FIELD_W-1:0] c, input logic [FIELD_W-1:0] d,
                                  input logic [FIELD_W-1:0] e, input string txt);
    seg_in_t s;
    s.out_column    = a;
    s.source_index  = b;
    s.source_line   = c;
    s.source_column = d;
    s.name_index    = e;
    stim_segs = {stim_segs, s};
    stim_text = {stim_text, txt};
  endfunction

  // Random field: pick a bit length first so every character count shows up
  // about equally often; now and then a fully random 31-bit value.
  function automatic logic [FIELD_W-1:0] rand_field();
    int unsigned        len;
    logic [FIELD_W-1:0] v;
    if ($urandom_range(7, 0) == 0) return FIELD_W'($urandom);
    len = $urandom_range(FIELD_W, 0);
    if (len == 0) return '0;
    v = FIELD_W'($urandom) & FIELD_W'((64'd1 << len) - 64'd1);
    v[len-1] = 1'b1;
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  // valid gets at most one assignment per falling edge.
  task automatic send_segment(input seg_in_t seg, input string typed);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= seg_in_t'($bits(seg_in_t)'({$urandom, $urandom, $urandom,
                                              $urandom, $urandom}));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= seg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer happened at this edge
    if (typed.len() != 0) queue_segment_chars(typed);
    else                  queue_segment_chars(vlq_segment_text(seg));
    @(negedge clk);
  endtask

  // Receiver: stall at random, decided at the falling edge.
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Output checker: a character counts when valid and ready are high at the
  // rising edge; values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h", out_data.code_char));
      end else begin
        next_char = expected_chars.pop_front();
        if (out_data.code_char !== next_char.code_char)
          report_mismatch($sformatf("code_char 0x%02h, want 0x%02h",
                                    out_data.code_char, next_char.code_char));
        if (out_data.field_done !== next_char.field_done)
          report_mismatch($sformatf("field_done %b, want %b",
                                    out_data.field_done, next_char.field_done));
        if (out_data.segment_done !== next_char.segment_done)
          report_mismatch($sformatf("segment_done %b, want %b",
                                    out_data.segment_done, next_char.segment_done));
      end
      char_count++;
    end
  end

  initial begin
    seg_in_t seg;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    mismatch_count = 0;
    char_count     = 0;
    send_idle_pct  = 14;
    recv_idle_pct  = 79;

    // Directed rows. Typed strings are read straight off the encoding:
    // zero is 'A', 1 is 'C', 15 is 'e', 16 needs a second group ("gB"),
    // and the largest value fills all seven groups ("+/////D").
    add_row('0, '0, '0, '0, '0, "A,A,A,A,A");
    add_row(FMAX, FMAX, FMAX, FMAX, FMAX,
            "+/////D,+/////D,+/////D,+/////D,+/////D");
    add_row(31'd0, 31'd1, 31'd15, 31'd16, FMAX, "A,C,e,gB,+/////D");
    // one field at its top, the rest zero
    add_row(FMAX, '0, '0, '0, '0, "");
    add_row('0, FMAX, '0, '0, '0, "");
    add_row('0, '0, FMAX, '0, '0, "");
    add_row('0, '0, '0, FMAX, '0, "");
    add_row('0, '0, '0, '0, FMAX, "");
    // group boundaries: last value of n characters and first of n+1
    add_row(31'd511, 31'd512, 31'd16383, 31'd16384, 31'd524287, "");
    add_row(31'd524288, 31'h00FF_FFFF, 31'h0100_0000, 31'h1FFF_FFFF, 31'h2000_0000, "");
    add_row(31'h4000_0000, 31'h3FFF_FFFF, 31'd1, 31'd0, 31'd3, "");
    // alternating bit patterns
    add_row(31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555, "");
    add_row(31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA, "");
    // walking ones across group positions
    add_row(31'd1 << 4, 31'd1 << 9, 31'd1 << 14, 31'd1 << 19, 31'd1 << 24, "");
    add_row(31'd1 << 29, 31'd1 << 30, 31'd1 << 5, 31'd1 << 10, 31'd1 << 15, "");
    add_row(31'd1 << 20, 31'd1 << 25, 31'd1 << 3, 31'd1 << 8, 31'd1 << 13, "");

    // reset held, then released at a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < stim_segs.size(); i++) send_segment(stim_segs[i], stim_text[i]);

    // three idle phases: slow receiver, slow sender, then no idling at all
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        seg.out_column    = rand_field();
        seg.source_index  = rand_field();
        seg.source_line   = rand_field();
        seg.source_column = rand_field();
        seg.name_index    = rand_field();
        send_segment(seg, "");
      end
    end
    in_valid <= 1'b0;

    // drain, then give stray characters a chance to show up
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
